/* hdl/mcg_pkg.sv */
// Shared types, register indexes and calendar helper functions for the grid generator.
package mcg_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int IDX_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [IDX_W-1:0] LAST_CELL = 6'd41;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WEEKDAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_OUTSIDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MONTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DAY       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MONTH     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DAY       = 3'd7;

  typedef struct packed {
    logic [2:0]         first_weekday;
    logic               show_outside_days;
    logic [YEAR_W-1:0]  min_year;
    logic [MONTH_W-1:0] min_month;
    logic [DAY_W-1:0]   min_day;
    logic [YEAR_W-1:0]  max_year;
    logic [MONTH_W-1:0] max_month;
    logic [DAY_W-1:0]   max_day;
  } cfg_t;

  // one month layout, handed from front to back
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  prev_year;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  next_year;
    logic [MONTH_W-1:0] next_month;
    logic [DAY_W-1:0]   cur_len;
    logic [DAY_W-1:0]   prev_len;
    logic [2:0]         offset;
  } desc_t;

  // y / 100 by reciprocal, exact for every 14-bit y
  function automatic logic [7:0] f_div100(input logic [YEAR_W-1:0] y);
    logic [27:0] p;
    p = 28'(y) * 28'd5243;
    return p[26:19];
  endfunction

  // leap year test, q is y / 100
  function automatic logic f_leap(input logic [YEAR_W-1:0] y, input logic [7:0] q);
    logic [YEAR_W-1:0] r;
    r = y - 14'(q) * 14'd100;
    if (r == '0) begin
      return (q[1:0] == 2'b00);
    end
    return (y[1:0] == 2'b00);
  endfunction

  // month length, m in 1..12
  function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Sakamoto month offsets
  function automatic logic [2:0] f_sak_off(input logic [MONTH_W-1:0] m);
    logic [2:0] o;
    case (m)
      4'd1:    o = 3'd0;
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd5:    o = 3'd0;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      default: o = 3'd4;
    endcase
    return o;
  endfunction

  // a bound date counts only when it is a real date
  function automatic logic f_bound_valid(input logic [YEAR_W-1:0] y,
                                         input logic [MONTH_W-1:0] m,
                                         input logic [DAY_W-1:0] d);
    logic lp;
    lp = f_leap(y, f_div100(y));
    if (y == '0 || m == '0 || m > 4'd12 || d == '0) begin
      return 1'b0;
    end
    return (d <= f_month_len(m, lp));
  endfunction

endpackage

/* hdl/mcg_front.sv */
// Front end: takes requests and works out the month layout in a short pipeline.
module mcg_front import mcg_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  in_view_year,
  input  logic [MONTH_W-1:0] in_view_month,
  input  logic [2:0]         first_weekday,
  input  logic               pop,
  output logic               push,
  output desc_t              push_desc
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // requests in the pipeline plus the queue may not exceed the queue depth
  assign busy   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign accept = start & ~busy;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // stage 1: clamp year and month, pick the weekday year
  logic [YEAR_W-1:0]  y_c, yw_c;
  logic [MONTH_W-1:0] m_c;
  logic               v1_r;
  logic [YEAR_W-1:0]  y1_r, yw1_r;
  logic [MONTH_W-1:0] m1_r;

  always_comb begin
    if (in_view_year == '0) begin
      y_c = 14'd1;
    end else if (in_view_year > 14'd9999) begin
      y_c = 14'd9999;
    end else begin
      y_c = in_view_year;
    end
    if (in_view_month == '0) begin
      m_c = 4'd1;
    end else if (in_view_month > 4'd12) begin
      m_c = 4'd12;
    end else begin
      m_c = in_view_month;
    end
    yw_c = (m_c < 4'd3) ? y_c - 1'b1 : y_c;
  end

  // stage 2: centuries of both years
  logic               v2_r;
  logic [YEAR_W-1:0]  y2_r, yw2_r;
  logic [MONTH_W-1:0] m2_r;
  logic [7:0]         qw2_r, qc2_r;

  // stage 3: weekday sum, neighbor months and lengths
  logic               leap3;
  logic [YEAR_W-1:0]  s3_c;
  desc_t              d3_c;
  logic               v3_r;
  logic [YEAR_W-1:0]  s3_r;
  desc_t              d3_r;

  always_comb begin
    leap3 = f_leap(y2_r, qc2_r);
    s3_c  = yw2_r + (yw2_r >> 2) - 14'(qw2_r) + 14'(qw2_r >> 2)
          + 14'(f_sak_off(m2_r)) + 14'd1;
    d3_c            = '0;
    d3_c.year       = y2_r;
    d3_c.month      = m2_r;
    d3_c.prev_month = (m2_r == 4'd1) ? 4'd12 : m2_r - 1'b1;
    d3_c.next_month = (m2_r == 4'd12) ? 4'd1 : m2_r + 1'b1;
    d3_c.prev_year  = y2_r;
    if (m2_r == 4'd1 && y2_r != 14'd1) begin
      d3_c.prev_year = y2_r - 1'b1;
    end
    d3_c.next_year  = (m2_r == 4'd12) ? y2_r + 1'b1 : y2_r;
    d3_c.cur_len    = f_month_len(m2_r, leap3);
    // previous month is February only when it lies in the same year
    d3_c.prev_len   = f_month_len(d3_c.prev_month, leap3);
  end

  // stage 4: divide the sum by seven
  logic [28:0]       p7_c;
  logic              v4_r;
  logic [11:0]       q7_4_r;
  logic [YEAR_W-1:0] s4_r;
  desc_t             d4_r;

  assign p7_c = 29'(s3_r) * 29'd18725;

  // remainder, then column of the 1st
  logic [YEAR_W-1:0] w14;
  logic [2:0]        wk;
  logic [3:0]        t;

  always_comb begin
    w14  = s4_r - 14'(q7_4_r) * 14'd7;
    wk   = (first_weekday == 3'd7) ? 3'd0 : first_weekday;
    t    = {1'b0, w14[2:0]} + 4'd7 - {1'b0, wk};
    push_desc        = d4_r;
    push_desc.offset = (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
  end

  assign push = v4_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      v1_r  <= accept;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    y1_r   <= y_c;
    m1_r   <= m_c;
    yw1_r  <= yw_c;
    y2_r   <= y1_r;
    m2_r   <= m1_r;
    yw2_r  <= yw1_r;
    qw2_r  <= f_div100(yw1_r);
    qc2_r  <= f_div100(y1_r);
    s3_r   <= s3_c;
    d3_r   <= d3_c;
    q7_4_r <= p7_c[28:17];
    s4_r   <= s3_r;
    d4_r   <= d3_r;
  end

endmodule

/* hdl/mcg_queue.sv */
// Small register queue of month layouts between front and back.
module mcg_queue import mcg_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  q_valid,
  output desc_t q_desc
);

  // the user must set DEPTH to at least 2; the block itself does not check it
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_valid = (count_r != '0);
  assign q_desc  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

/* hdl/mcg_back.sv */
// Back end: walks the 42 grid cells of one month layout, one cell per cycle.
module mcg_back import mcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  desc_t              q_desc,
  output logic               pop,
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_cell_index,
  output logic [YEAR_W-1:0]  out_cell_year,
  output logic [MONTH_W-1:0] out_cell_month,
  output logic [DAY_W-1:0]   out_cell_day,
  output logic               out_in_current_month,
  output logic               out_visible,
  output logic               out_in_range,
  output logic               out_last
);

  logic             active_r;
  logic [IDX_W-1:0] idx_r;
  desc_t            desc_r;
  logic             lo_on_r, hi_on_r;
  logic             out_valid_r;

  // next layout loads on the last cell, so runs follow without a gap
  assign pop = q_valid & (~active_r | (idx_r == LAST_CELL));

  // cell date
  logic [6:0]         j;
  logic [6:0]         pd;
  logic [YEAR_W-1:0]  cy;
  logic [MONTH_W-1:0] cm;
  logic [DAY_W-1:0]   cd;
  logic               cur;
  logic [22:0]        key, lo_key, hi_key;
  logic               ok;

  always_comb begin
    j  = 7'(idx_r) - 7'(desc_r.offset) + 7'd1;
    pd = 7'(desc_r.prev_len) + 7'(idx_r) + 7'd1 - 7'(desc_r.offset);
    if (idx_r < 6'(desc_r.offset)) begin
      cy  = desc_r.prev_year;
      cm  = desc_r.prev_month;
      cd  = pd[4:0];
      cur = 1'b0;
    end else if (j > 7'(desc_r.cur_len)) begin
      cy  = desc_r.next_year;
      cm  = desc_r.next_month;
      cd  = 5'(j - 7'(desc_r.cur_len));
      cur = 1'b0;
    end else begin
      cy  = desc_r.year;
      cm  = desc_r.month;
      cd  = j[4:0];
      cur = 1'b1;
    end
    key    = {cy, cm, cd};
    lo_key = {cfg.min_year, cfg.min_month, cfg.min_day};
    hi_key = {cfg.max_year, cfg.max_month, cfg.max_day};
    ok     = ~(lo_on_r && key < lo_key) & ~(hi_on_r && key > hi_key);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
      if (pop) begin
        active_r <= 1'b1;
        idx_r    <= '0;
      end else if (active_r) begin
        if (idx_r == LAST_CELL) begin
          active_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    lo_on_r <= f_bound_valid(cfg.min_year, cfg.min_month, cfg.min_day);
    hi_on_r <= f_bound_valid(cfg.max_year, cfg.max_month, cfg.max_day);
    if (pop) begin
      desc_r <= q_desc;
    end
    out_cell_index       <= idx_r;
    out_cell_year        <= cy;
    out_cell_month       <= cm;
    out_cell_day         <= cd;
    out_in_current_month <= cur;
    out_visible          <= cur | cfg.show_outside_days;
    out_in_range         <= ok;
    out_last             <= (idx_r == LAST_CELL);
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/month_calendar_grid_generator_core.sv */
// Top level of the month calendar grid generator: config registers and block wiring.
//
// A request (start high while busy is low) names a year and month; the block then
// emits the 42 cells of a six-by-seven month grid, row by row, one word per cycle on
// out_valid, with out_last on cell 41. The receiver cannot stall, so each word must be
// taken in the cycle it is shown. A request passes the front-end stages and waits in
// the queue while an earlier one is walked; the back end loads the next one on the last
// cell, and up to QUEUE_DEPTH requests may wait behind the one being walked, so busy
// only rises when that many are waiting. The user must write configuration only while
// no request is pending; the block itself does not enforce it.
module month_calendar_grid_generator_core import mcg_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [YEAR_W-1:0]     in_view_year,
  input  logic [MONTH_W-1:0]    in_view_month,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_cell_index,
  output logic [YEAR_W-1:0]     out_cell_year,
  output logic [MONTH_W-1:0]    out_cell_month,
  output logic [DAY_W-1:0]      out_cell_day,
  output logic                  out_in_current_month,
  output logic                  out_visible,
  output logic                  out_in_range,
  output logic                  out_last
);

  cfg_t  cfg_r;
  logic  push, pop, q_valid;
  desc_t push_desc, q_desc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{first_weekday: 3'd0, show_outside_days: 1'b1,
                 min_year: '0, min_month: '0, min_day: '0,
                 max_year: '0, max_month: '0, max_day: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_WEEKDAY: cfg_r.first_weekday     <= cfg_wdata[2:0];
        CFG_SHOW_OUTSIDE:  cfg_r.show_outside_days <= cfg_wdata[0];
        CFG_MIN_YEAR:      cfg_r.min_year          <= cfg_wdata;
        CFG_MIN_MONTH:     cfg_r.min_month         <= cfg_wdata[3:0];
        CFG_MIN_DAY:       cfg_r.min_day           <= cfg_wdata[4:0];
        CFG_MAX_YEAR:      cfg_r.max_year          <= cfg_wdata;
        CFG_MAX_MONTH:     cfg_r.max_month         <= cfg_wdata[3:0];
        CFG_MAX_DAY:       cfg_r.max_day           <= cfg_wdata[4:0];
        default:           cfg_r                   <= cfg_r;
      endcase
    end
  end

  mcg_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_view_year  (in_view_year),
    .in_view_month (in_view_month),
    .first_weekday (cfg_r.first_weekday),
    .pop           (pop),
    .push          (push),
    .push_desc     (push_desc)
  );

  mcg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  mcg_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_desc               (q_desc),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_cell_index       (out_cell_index),
    .out_cell_year        (out_cell_year),
    .out_cell_month       (out_cell_month),
    .out_cell_day         (out_cell_day),
    .out_in_current_month (out_in_current_month),
    .out_visible          (out_visible),
    .out_in_range         (out_in_range),
    .out_last             (out_last)
  );

endmodule
